// ===== rtl/neural_activation_unit_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the activation unit
// Concurrent checks written in a single line per use, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH
`define NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nau: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nau: next-cycle check failed");

`endif

// ===== rtl/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// nau_pkg
// Shared constants, types and lookup tables of the activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

    // Segments of the 2^f fraction table.
    localparam int EXP_TABLE_DEPTH = 32;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_TAB_IDX_W   = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int EXP_POS_W       = 10 + EXP_IDX_W;
    localparam int EXP_W           = 16;

    localparam int RCP_SEGS      = 32;
    localparam int RCP_TAB_IDX_W = $clog2(RCP_SEGS + 1);
    localparam int RCP_W         = 17;

    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam logic signed [15:0] LOG2E_Q14 = 16'sd23637;
    localparam logic signed [15:0] ONE_Q10   = 16'sd1024;
    localparam logic [14:0]        ONE_Q14   = 15'd16384;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd1;

    localparam logic [14:0] ALPHA_RESET = 15'd1024;

    typedef enum logic [1:0] {
        MODE_SIGMOID = 2'd0,
        MODE_RELU    = 2'd1,
        MODE_LEAKY   = 2'd2,
        MODE_ELU     = 2'd3
    } t_mode;

    // Per-request information that rides along with the exp pipeline.
    typedef struct packed {
        logic signed [15:0] z;
        logic               func;
        t_mode              mode;
        logic signed [15:0] leaky;
    } t_side;

    typedef logic [EXP_W-1:0] t_exp2_tab [EXP_TABLE_DEPTH+1];
    typedef logic [RCP_W-1:0] t_rcp_tab [RCP_SEGS+1];

    // Shift-and-subtract division; only the table builders call it.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 2^(i/D) in Q.14 from a truncated Taylor series of exp(i*ln2/D).
    function automatic t_exp2_tab build_exp2_tab();
        t_exp2_tab       tab;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            x    = udiv64(LN2_Q30 * longint'(i), 64'(EXP_TABLE_DEPTH));
            term = 64'd1 << 30;
            sum  = term;
            for (int k = 1; k <= 24; k++) begin
                term = udiv64((term * x) >> 30, 64'(k));
                sum  = sum + term;
            end
            tab[i] = EXP_W'((sum + (64'd1 << 15)) >> 16);
        end
        return tab;
    endfunction

    // 1/(1+i/32) in Q.16, rounded to nearest.
    function automatic t_rcp_tab build_rcp_tab();
        t_rcp_tab        tab;
        longint unsigned d;
        for (int i = 0; i <= RCP_SEGS; i++) begin
            d      = longint'(RCP_SEGS + i);
            tab[i] = RCP_W'(udiv64((64'd1 << 21) + (d >> 1), d));
        end
        return tab;
    endfunction

    localparam t_exp2_tab EXP2_TAB = build_exp2_tab();
    localparam t_rcp_tab  RCP_TAB  = build_rcp_tab();

endpackage

// ===== rtl/nau_exp.sv =====
// ----------------------------------------------------------------------------
// nau_exp
// Three-stage exp(x) for x <= 0: fraction table, interpolation, shift.
// ----------------------------------------------------------------------------
module nau_exp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_prod,
    input  nau_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic [14:0]          o_e,
    output nau_pkg::t_side       o_side
);

    logic signed [17:0]                t_q10;
    logic signed [7:0]                 n_int;
    logic [9:0]                        frac;
    logic [7:0]                        sh_full;
    logic [nau_pkg::EXP_POS_W-1:0]     pos;
    logic [nau_pkg::EXP_IDX_W-1:0]     idx;
    logic [nau_pkg::EXP_TAB_IDX_W-1:0] tab_idx;
    logic [nau_pkg::EXP_W-1:0]         tab_lo;
    logic [nau_pkg::EXP_W-1:0]         tab_hi;
    logic [25:0]                       step;

    logic                      r_s1_valid;
    logic [nau_pkg::EXP_W-1:0] r_s1_lo;
    logic [nau_pkg::EXP_W-1:0] r_s1_diff;
    logic [9:0]                r_s1_rem;
    logic [4:0]                r_s1_sh;
    logic                      r_s1_big;
    nau_pkg::t_side            r_s1_side;

    logic                      r_s2_valid;
    logic [15:0]               r_s2_m;
    logic [4:0]                r_s2_sh;
    logic                      r_s2_big;
    nau_pkg::t_side            r_s2_side;

    logic                      r_s3_valid;
    logic [14:0]               r_s3_e;
    nau_pkg::t_side            r_s3_side;

    // t = floor(x*log2e) in Q.10, split into integer and fraction parts.
    always_comb begin
        t_q10   = $signed(i_prod[31:14]);
        n_int   = $signed(t_q10[17:10]);
        frac    = t_q10[9:0];
        sh_full = 8'(-n_int);
        pos     = nau_pkg::EXP_POS_W'(frac) * nau_pkg::EXP_POS_W'(nau_pkg::EXP_TABLE_DEPTH);
        idx     = pos[nau_pkg::EXP_POS_W-1:10];
        tab_idx = nau_pkg::EXP_TAB_IDX_W'(idx);
        tab_lo  = nau_pkg::EXP2_TAB[tab_idx];
        tab_hi  = nau_pkg::EXP2_TAB[tab_idx + 1'b1];
        step    = 26'(r_s1_diff) * 26'(r_s1_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lo   <= tab_lo;
        r_s1_diff <= tab_hi - tab_lo;
        r_s1_rem  <= pos[9:0];
        r_s1_sh   <= sh_full[4:0];
        r_s1_big  <= (sh_full[7:5] != 3'd0);
        r_s1_side <= i_side;

        r_s2_m    <= r_s1_lo + step[25:10];
        r_s2_sh   <= r_s1_sh;
        r_s2_big  <= r_s1_big;
        r_s2_side <= r_s1_side;

        // Beyond 31 bits of shift the power of two underflows to zero.
        r_s3_e    <= r_s2_big ? 15'd0 : 15'(r_s2_m >> r_s2_sh);
        r_s3_side <= r_s2_side;
    end

    assign o_valid = r_s3_valid;
    assign o_e     = r_s3_e;
    assign o_side  = r_s3_side;

endmodule

// ===== rtl/nau_act.sv =====
// ----------------------------------------------------------------------------
// nau_act
// Four-stage back end: sigmoid reciprocal, ELU scaling, result selection.
// ----------------------------------------------------------------------------
`include "neural_activation_unit_top_assert.svh"

module nau_act (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [14:0]          i_alpha,
    input  logic                 i_valid,
    input  logic [14:0]          i_e,
    input  nau_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic signed [15:0]   o_y
);

    logic [nau_pkg::RCP_TAB_IDX_W-1:0] seg;
    logic [nau_pkg::RCP_W-1:0]         rcp_lo;
    logic [nau_pkg::RCP_W-1:0]         rcp_hi;
    logic signed [16:0]                em1;
    logic signed [32:0]                elu_full;
    logic [25:0]                       rcp_step;
    logic signed [30:0]                elu_round;
    logic [17:0]                       r_round;
    logic [10:0]                       s_pos;
    logic signed [16:0]                elu_d;
    logic [21:0]                       sd_prod;
    logic [21:0]                       sd_round;
    logic signed [15:0]                sig_y;
    logic signed [15:0]                pos_y;
    logic                              z_pos;
    logic signed [15:0]                n_y;

    logic                      r_s1_valid;
    logic [nau_pkg::RCP_W-1:0] r_s1_lo;
    logic [nau_pkg::RCP_W-1:0] r_s1_diff;
    logic [8:0]                r_s1_rem;
    logic signed [30:0]        r_s1_elu_p;
    nau_pkg::t_side            r_s1_side;

    logic                      r_s2_valid;
    logic [16:0]               r_s2_r;
    logic signed [15:0]        r_s2_elu_v;
    nau_pkg::t_side            r_s2_side;

    logic                      r_s3_valid;
    logic [10:0]               r_s3_s;
    logic signed [15:0]        r_s3_elu_y;
    nau_pkg::t_side            r_s3_side;

    logic                      r_o_valid;
    logic signed [15:0]        r_o_y;

    always_comb begin
        seg      = i_e[14:9];
        rcp_lo   = nau_pkg::RCP_TAB[seg];
        rcp_hi   = nau_pkg::RCP_TAB[seg[4:0] + 6'd1];
        em1      = $signed({2'b00, i_e}) - $signed({2'b00, nau_pkg::ONE_Q14});
        elu_full = $signed({1'b0, i_alpha}) * em1;

        rcp_step  = 26'(r_s1_diff) * 26'(r_s1_rem);
        elu_round = r_s1_elu_p + 31'sd8192;

        r_round = 18'(r_s2_r) + 18'd32;
        s_pos   = r_round[16:6];
        elu_d   = 17'(r_s2_elu_v) + $signed({2'b00, i_alpha});

        sd_prod  = 22'(r_s3_s) * 22'(11'd1024 - r_s3_s);
        sd_round = sd_prod + 22'd512;
        sig_y    = r_s3_side.func ? $signed({7'd0, sd_round[18:10]})
                                  : $signed({5'd0, r_s3_s});
        z_pos    = !r_s3_side.z[15] && (r_s3_side.z != 16'sd0);
        pos_y    = r_s3_side.func ? nau_pkg::ONE_Q10 : r_s3_side.z;

        case (r_s3_side.mode)
            nau_pkg::MODE_SIGMOID: n_y = sig_y;
            nau_pkg::MODE_RELU:    n_y = z_pos ? pos_y : 16'sd0;
            nau_pkg::MODE_LEAKY: begin
                if (z_pos) begin
                    n_y = pos_y;
                end else begin
                    n_y = r_s3_side.func ? $signed({1'b0, i_alpha}) : r_s3_side.leaky;
                end
            end
            nau_pkg::MODE_ELU:     n_y = z_pos ? pos_y : r_s3_elu_y;
            default:               n_y = 16'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // The last segment only covers e equal to one, where no slope is needed.
        if (seg[5]) begin
            r_s1_lo   <= nau_pkg::RCP_TAB[nau_pkg::RCP_SEGS];
            r_s1_diff <= '0;
        end else begin
            r_s1_lo   <= rcp_lo;
            r_s1_diff <= rcp_lo - rcp_hi;
        end
        r_s1_rem   <= i_e[8:0];
        r_s1_elu_p <= 31'(elu_full);
        r_s1_side  <= i_side;

        r_s2_r     <= r_s1_lo - rcp_step[25:9];
        r_s2_elu_v <= $signed(elu_round[29:14]);
        r_s2_side  <= r_s1_side;

        // The table gives sigmoid of the magnitude; a negative z mirrors it.
        r_s3_s     <= r_s2_side.z[15] ? 11'd1024 - s_pos : s_pos;
        r_s3_elu_y <= r_s2_side.func ? 16'(elu_d) : r_s2_elu_v;
        r_s3_side  <= r_s2_side;

        r_o_y      <= n_y;
    end

    assign o_valid = r_o_valid;
    assign o_y     = r_o_y;

    `NAU_ASSERT_NEXT(a_valid_advance, i_clk, i_rst_n, 1'b1, o_valid == $past(r_s3_valid))
    `NAU_ASSERT_SAME(a_sig_bounded, i_clk, i_rst_n, r_s3_valid, r_s3_s <= 11'd1024)
    `NAU_ASSERT_NEXT(a_sig_range, i_clk, i_rst_n, r_s3_valid && r_s3_side.mode == nau_pkg::MODE_SIGMOID, !o_y[15] && o_y <= 16'sd1024)
    `NAU_ASSERT_NEXT(a_relu_neg_zero, i_clk, i_rst_n, r_s3_valid && r_s3_side.mode == nau_pkg::MODE_RELU && !z_pos, o_y == 16'sd0)

endmodule

// ===== rtl/neural_activation_unit_top.sv =====
// ----------------------------------------------------------------------------
// neural_activation_unit_top
// Sigmoid, ReLU, leaky ReLU and ELU activation or derivative, Q5.10.
// ----------------------------------------------------------------------------
// The unit takes one request per clock and never reports busy. Each result
// appears on o_y with o_valid high for exactly one cycle once it has passed
// through the pipeline: one input stage with the exponent and leaky
// multipliers, three exp stages, and four stages for the reciprocal, ELU
// scaling and output selection. Results cannot be held off, so the receiver
// must take every strobe. The tables are constants, so no clearing pass
// follows reset. Mode and alpha are to be written through the configuration
// port only while no request is in flight; the unit does not enforce this.
module neural_activation_unit_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [15:0]                i_z,
    input  logic                              i_func,
    output logic                              o_valid,
    output logic signed [15:0]                o_y,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nau_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nau_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    nau_pkg::t_mode      r_mode;
    logic [14:0]         r_alpha;

    logic                r_s0_valid;
    logic signed [31:0]  r_s0_prod;
    logic signed [30:0]  r_s0_leaky_p;
    logic signed [15:0]  r_s0_z;
    logic                r_s0_func;
    nau_pkg::t_mode      r_s0_mode;

    logic                z_pos;
    logic signed [16:0]  z_ext;
    logic signed [16:0]  x_neg;
    logic signed [32:0]  leaky_full;
    logic signed [30:0]  leaky_round;
    logic signed [20:0]  leaky_q;
    nau_pkg::t_side      side;

    logic                exp_valid;
    logic [14:0]         exp_e;
    nau_pkg::t_side      exp_side;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= nau_pkg::MODE_RELU;
            r_alpha <= nau_pkg::ALPHA_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nau_pkg::REG_MODE:  r_mode  <= nau_pkg::t_mode'(i_cfg_data[1:0]);
                nau_pkg::REG_ALPHA: r_alpha <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // exp is only ever taken of -|z| (sigmoid) or of z <= 0 (ELU).
    always_comb begin
        z_ext      = {i_z[15], i_z};
        z_pos      = !i_z[15] && (i_z != 16'sd0);
        x_neg      = z_pos ? -z_ext : z_ext;
        leaky_full = $signed({1'b0, r_alpha}) * z_ext;

        leaky_round = r_s0_leaky_p + 31'sd512;
        leaky_q     = $signed(leaky_round[30:10]);
        side.z      = r_s0_z;
        side.func   = r_s0_func;
        side.mode   = r_s0_mode;
        if (leaky_q > 21'sd32767) begin
            side.leaky = 16'sd32767;
        end else if (leaky_q < -21'sd32768) begin
            side.leaky = -16'sd32768;
        end else begin
            side.leaky = leaky_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_prod    <= 32'(x_neg * nau_pkg::LOG2E_Q14);
        r_s0_leaky_p <= 31'(leaky_full);
        r_s0_z       <= i_z;
        r_s0_func    <= i_func;
        r_s0_mode    <= r_mode;
    end

    nau_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_prod  (r_s0_prod),
        .i_side  (side),
        .o_valid (exp_valid),
        .o_e     (exp_e),
        .o_side  (exp_side)
    );

    nau_act u_act (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_alpha (r_alpha),
        .i_valid (exp_valid),
        .i_e     (exp_e),
        .i_side  (exp_side),
        .o_valid (o_valid),
        .o_y     (o_y)
    );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for neural_activation_unit_top. A queue of requests
// feeds a clocked driver with random idle bursts. A clocked monitor predicts
// each accepted request in Q5.10 and compares every result strobe in order.
// Mode and alpha are changed between drained phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nau_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASES         = 16;
    localparam int REQS_PER_PHASE = 84;
    localparam int CALM_PHASES    = 2;

    localparam int EXP_SEGS  = 32;
    localparam int RCP_STEPS = 32;
    localparam longint          K_LOG2E   = 23637;
    localparam longint unsigned K_LN2_Q30 = 64'd744261118;
    localparam longint          Q10_ONE   = 1024;
    localparam longint          Q14_ONE   = 16384;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI   = 2'd3;
    localparam logic [CFG_DATA_W-1:0] ALPHA_AT_RESET = 15'd1024;
    localparam logic [CFG_DATA_W-1:0] ALPHA_MAX      = 15'd32767;

    localparam logic signed [15:0] Z_MIN = 16'sh8000;
    localparam logic signed [15:0] Z_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [15:0] z;
        logic               func;
    } t_act_req;

    typedef struct {
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               func;
        t_mode              mode;
    } t_y_due;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic signed [15:0]        i_z         = '0;
    logic                      i_func      = 1'b0;
    logic                      o_valid;
    logic signed [15:0]        o_y;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data  = '0;

    t_act_req        act_req_q[$];
    t_y_due          y_due_q[$];
    longint unsigned exp2_lut[EXP_SEGS+1];
    longint unsigned rcp_lut[RCP_STEPS+1];

    t_mode                 cur_mode  = MODE_RELU;
    logic [CFG_DATA_W-1:0] cur_alpha = ALPHA_AT_RESET;
    logic                  req_taken = 1'b0;
    bit                    idling_on = 1'b1;
    int                    gap_left  = 0;
    int                    err_count = 0;
    int                    y_checked = 0;
    int                    reg_writes = 0;
    int                    cycle_cnt = 0;

    neural_activation_unit_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_z         (i_z),
        .i_func      (i_func),
        .o_valid     (o_valid),
        .o_y         (o_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // 2^(i/32) in Q.14 from a Taylor series, and 1/(1+i/32) in Q.16.
    function automatic void fill_luts();
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned d;
        for (int i = 0; i <= EXP_SEGS; i++) begin
            x    = (K_LN2_Q30 * i) / EXP_SEGS;
            term = 64'd1 << 30;
            acc  = term;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * x) >> 30) / k;
                acc  = acc + term;
            end
            exp2_lut[i] = (acc + (64'd1 << 15)) >> 16;
        end
        for (int i = 0; i <= RCP_STEPS; i++) begin
            d          = RCP_STEPS + i;
            rcp_lut[i] = ((64'd1 << 21) + d / 2) / d;
        end
    endfunction

    function automatic longint sat_q510(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // exp(x) for x <= 0, x in Q.10, result in Q.14.
    function automatic longint exp_q14(input longint x);
        longint t;
        longint n;
        longint pos;
        longint idx;
        longint rem;
        longint lo;
        longint hi;
        longint m;
        longint sh;
        t   = (x * K_LOG2E) >>> 14;
        n   = t >>> 10;
        pos = (t - n * 1024) * EXP_SEGS;
        idx = (pos >>> 10) % EXP_SEGS;
        rem = pos & 1023;
        lo  = longint'(exp2_lut[idx]);
        hi  = longint'(exp2_lut[idx + 1]);
        m   = lo + (((hi - lo) * rem) >>> 10);
        sh  = -n;
        if (sh <= 0) return m;
        if (sh > 31) return 0;
        return m >>> sh;
    endfunction

    function automatic longint sigmoid_pos(input longint a);
        longint e;
        longint seg;
        longint rem;
        longint lo;
        longint hi;
        longint r;
        e   = exp_q14(-a);
        seg = e >>> 9;
        rem = e & 511;
        if (seg >= RCP_STEPS) begin
            r = longint'(rcp_lut[RCP_STEPS]);
        end else begin
            lo = longint'(rcp_lut[seg]);
            hi = longint'(rcp_lut[seg + 1]);
            r  = lo - (((lo - hi) * rem) >>> 9);
        end
        return (r + 32) >>> 6;
    endfunction

    function automatic logic signed [15:0] calc_act_y(input logic signed [15:0] z16,
                                                      input logic deriv, input t_mode md,
                                                      input logic [CFG_DATA_W-1:0] a15);
        longint z;
        longint a;
        longint s;
        longint v;
        longint y;
        z = z16;
        a = a15;
        y = 0;
        case (md)
            MODE_SIGMOID: begin
                s = (z >= 0) ? sigmoid_pos(z) : Q10_ONE - sigmoid_pos(-z);
                y = deriv ? ((s * (Q10_ONE - s) + 512) >>> 10) : s;
            end
            MODE_RELU: begin
                y = (z <= 0) ? 0 : (deriv ? Q10_ONE : z);
            end
            MODE_LEAKY: begin
                if (z <= 0) y = deriv ? a : ((a * z + 512) >>> 10);
                else y = deriv ? Q10_ONE : z;
            end
            MODE_ELU: begin
                if (z <= 0) begin
                    v = sat_q510((a * (exp_q14(z) - Q14_ONE) + 8192) >>> 14);
                    y = deriv ? v + a : v;
                end else begin
                    y = deriv ? Q10_ONE : z;
                end
            end
        endcase
        return 16'(sat_q510(y));
    endfunction

    function automatic void queue_req(input logic signed [15:0] z, input logic f);
        act_req_q.push_back('{z: z, func: f});
    endfunction

    function automatic logic signed [15:0] pick_z();
        case ($urandom_range(0, 9))
            0: return Z_MIN;
            1: return Z_MAX;
            2, 3: return 16'(int'($urandom_range(0, 64)) - 32);
            4, 5: return 16'(int'($urandom_range(0, 16384)) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IDX_W'($urandom);
        i_cfg_data  <= CFG_DATA_W'($urandom);
        reg_writes++;
    endtask

    // Mode writes carry random upper data bits, which the unit must mask.
    task automatic write_mode(input t_mode md);
        write_reg(REG_MODE, {(CFG_DATA_W-2)'($urandom), md});
    endtask

    // Registers change only once nothing is queued or in flight.
    task automatic drain_pipe();
        while (act_req_q.size() != 0 || y_due_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Request driver: holds a request until taken, otherwise may idle a burst.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_taken) void'(act_req_q.pop_front());
            if (!start || req_taken) begin
                if (gap_left > 0 || act_req_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    start  <= 1'b0;
                    i_z    <= 16'($urandom);
                    i_func <= 1'($urandom);
                end else if (idling_on && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 15);
                    start  <= 1'b0;
                    i_z    <= 16'($urandom);
                    i_func <= 1'($urandom);
                end else begin
                    start  <= 1'b1;
                    i_z    <= act_req_q[0].z;
                    i_func <= act_req_q[0].func;
                end
            end
        end
    end

    // Monitor: tracks the registers, predicts accepted requests, checks results.
    always @(posedge i_clk) begin
        t_y_due due;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:  cur_mode = t_mode'(i_cfg_data[1:0]);
                    REG_ALPHA: cur_alpha = i_cfg_data;
                    default:   ;
                endcase
            end
            if ($isunknown(o_valid)) begin
                $display("%0t: o_valid unknown, expected 0 or 1, actual %b", $time, o_valid);
                err_count++;
            end else if (o_valid) begin
                if (y_due_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual y %0d",
                             $time, o_y);
                    err_count++;
                end else begin
                    due = y_due_q.pop_front();
                    y_checked++;
                    if (o_y !== due.y) begin
                        $display("%0t: y mismatch (%s z %0d func %0d) expected %0d actual %0d",
                                 $time, due.mode.name(), due.z, due.func, due.y, o_y);
                        err_count++;
                    end
                end
            end
            if (start && !busy) begin
                due.y    = calc_act_y(i_z, i_func, cur_mode, cur_alpha);
                due.z    = i_z;
                due.func = i_func;
                due.mode = cur_mode;
                y_due_q.push_back(due);
            end
            req_taken <= start && !busy;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_cnt, y_due_q.size());
            $display("neural_activation_unit_top verification failed");
            $finish;
        end
    end

    initial begin
        t_mode                 new_mode;
        logic [CFG_DATA_W-1:0] new_alpha;
        fill_luts();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings are ReLU with alpha of one.
        queue_req(Z_MIN, 1'b0);
        queue_req(16'sd0, 1'b1);
        queue_req(16'sd1, 1'b1);
        queue_req(Z_MAX, 1'b0);
        queue_req(-16'sd1, 1'b0);
        drain_pipe();

        // Sigmoid at the range ends drives exp into the fully shifted-out case.
        write_mode(MODE_SIGMOID);
        queue_req(Z_MIN, 1'b0);
        queue_req(Z_MIN, 1'b1);
        queue_req(Z_MAX, 1'b1);
        queue_req(16'sd0, 1'b0);
        queue_req(16'sd0, 1'b1);
        queue_req(-16'sd1, 1'b1);
        drain_pipe();

        // Leaky with the largest slope saturates; writes to unused indexes do nothing.
        write_mode(MODE_LEAKY);
        write_reg(REG_ALPHA, ALPHA_MAX);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        queue_req(Z_MIN, 1'b0);
        queue_req(-16'sd1, 1'b0);
        queue_req(-16'sd1, 1'b1);
        queue_req(Z_MAX, 1'b1);
        queue_req(16'sd0, 1'b0);
        drain_pipe();

        write_mode(MODE_ELU);
        queue_req(Z_MIN, 1'b0);
        queue_req(Z_MIN, 1'b1);
        queue_req(-16'sd1, 1'b0);
        queue_req(16'sd0, 1'b1);
        queue_req(16'sd100, 1'b0);

        // Every mode meets every kind of alpha over the sixteen phases.
        for (int ph = 0; ph < PHASES; ph++) begin
            new_mode = t_mode'(ph % 4);
            case ((ph / 4) % 4)
                0: new_alpha = '0;
                1: new_alpha = ALPHA_MAX;
                2: new_alpha = CFG_DATA_W'($urandom_range(0, 2047));
                default: new_alpha = CFG_DATA_W'($urandom);
            endcase
            drain_pipe();
            if (ph % 2 == 0) begin
                write_mode(new_mode);
                write_reg(REG_ALPHA, new_alpha);
            end else begin
                write_reg(REG_ALPHA, new_alpha);
                write_mode(new_mode);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            idling_on = (ph < PHASES - CALM_PHASES);
            for (int k = 0; k < REQS_PER_PHASE; k++) queue_req(pick_z(), 1'($urandom));
        end
        drain_pipe();

        $display("Checked %0d results across all four modes, both functions and %0d",
                 y_checked, reg_writes);
        $display("register writes, with alpha at zero, at its maximum and at random values.");
        if (err_count == 0) begin
            $display("neural_activation_unit_top verification clean");
        end else begin
            $display("neural_activation_unit_top verification failed");
        end
        $finish;
    end

endmodule
